// ===== src/lwwr_pkg.sv =====
// ----------------------------------------------------------------------------
// lwwr_pkg: shared types for the longest window within range block
// Payload structs of both channels.
// ----------------------------------------------------------------------------
package lwwr_pkg;

    localparam int unsigned SAMPLE_BITS = 32;
    localparam int unsigned LEN_BITS    = 11;
    localparam int unsigned LIMIT_BITS  = 32;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample_value;
        logic                   last_item;
    } in_word_t;

    typedef struct packed {
        logic [LEN_BITS-1:0] window_length;
        logic [LEN_BITS-1:0] best_length;
        logic                sequence_done;
    } out_word_t;

endpackage

// ===== src/lwwr_front.sv =====
// ----------------------------------------------------------------------------
// lwwr_front: input queue
// Accepts input words, masks the sample to the used value width and holds
// them in a small two-entry queue ahead of the deque engine.
// ----------------------------------------------------------------------------
module lwwr_front #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  lwwr_pkg::in_word_t       s_data,
    output logic                     q_valid,
    input  logic                     q_ready,
    output logic [VALUE_BITS-1:0]    q_value,
    output logic                     q_last
);

    localparam int unsigned UB = (VALUE_BITS < lwwr_pkg::SAMPLE_BITS) ?
                                 VALUE_BITS : lwwr_pkg::SAMPLE_BITS;

    logic [VALUE_BITS-1:0] val_reg [2];
    logic                  last_reg [2];
    logic                  wp_reg, rp_reg;
    logic [1:0]            cnt_reg;
    logic [VALUE_BITS-1:0] masked;
    logic                  push, pop;

    // zero-extend the used low bits of the sample
    always_comb begin
        masked = '0;
        masked[UB-1:0] = s_data.sample_value[UB-1:0];
    end

    assign s_ready = (cnt_reg != 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;
    assign q_value = val_reg[rp_reg];
    assign q_last  = last_reg[rp_reg];

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            val_reg[wp_reg]  <= masked;
            last_reg[wp_reg] <= s_data.last_item;
        end
    end

    // queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== src/lwwr_back.sv =====
// ----------------------------------------------------------------------------
// lwwr_back: deque engine
// Keeps max and min monotonic deques in ring memories, pops tails, pushes
// the new sample, drops expired heads and advances the window start.
// ----------------------------------------------------------------------------
module lwwr_back #(
    parameter int unsigned DEQUE_DEPTH = 1024,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [lwwr_pkg::LIMIT_BITS-1:0] range_limit,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [VALUE_BITS-1:0]         q_value,
    input  logic                          q_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output lwwr_pkg::out_word_t           m_data,
    output logic                          busy
);

    localparam int unsigned AW = (DEQUE_DEPTH > 1) ? $clog2(DEQUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEQUE_DEPTH + 1);
    localparam int unsigned PW = 32;
    localparam int unsigned DW = (VALUE_BITS > PW) ? VALUE_BITS : PW;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEQUE_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(DEQUE_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_TAILR = 8'b00000010,
        S_TAILC = 8'b00000100,
        S_PUSH  = 8'b00001000,
        S_HEADR = 8'b00010000,
        S_HEADC = 8'b00100000,
        S_CHECK = 8'b01000000,
        S_OUT   = 8'b10000000
    } state_t;

    state_t state_reg;

    // deque memories: value and position per entry
    logic [VALUE_BITS-1:0] mx_val [DEQUE_DEPTH];
    logic [PW-1:0]         mx_pos [DEQUE_DEPTH];
    logic [VALUE_BITS-1:0] mn_val [DEQUE_DEPTH];
    logic [PW-1:0]         mn_pos [DEQUE_DEPTH];

    logic [AW-1:0] mx_head_reg, mn_head_reg;
    logic [CW-1:0] mx_tail_reg, mn_tail_reg;
    logic [PW-1:0] pos_reg, start_reg;
    logic [lwwr_pkg::LEN_BITS-1:0] best_reg;
    logic [VALUE_BITS-1:0] v_reg;
    logic          last_reg;
    logic          side_reg;     // head pass for the window cap, tail scan follows

    logic [VALUE_BITS-1:0] rd_mxv_reg, rd_mnv_reg;
    logic [PW-1:0]         rd_mxp_reg, rd_mnp_reg;

    logic                  out_valid_reg;
    lwwr_pkg::out_word_t   out_reg;

    // ring address helpers
    function automatic logic [AW-1:0] ring(input logic [AW-1:0] h,
                                           input logic [CW-1:0] k);
        logic [CW:0] s;
        begin
            s = {{(CW+1-AW){1'b0}}, h} + {1'b0, k};
            if (s >= {1'b0, DEPTH_C}) s = s - {1'b0, DEPTH_C};
            return s[AW-1:0];
        end
    endfunction

    logic [PW-1:0] win_len;
    logic [AW-1:0] mx_rd_addr, mn_rd_addr;
    logic          mx_exp, mn_exp;

    assign win_len = pos_reg - start_reg;
    assign mx_exp  = (pos_reg - rd_mxp_reg) >= win_len;
    assign mn_exp  = (pos_reg - rd_mnp_reg) >= win_len;

    // read addresses: tail entry during tail scan, head otherwise
    always_comb begin
        if (state_reg == S_TAILR) begin
            mx_rd_addr = ring(mx_head_reg, mx_tail_reg - CW'(1));
            mn_rd_addr = ring(mn_head_reg, mn_tail_reg - CW'(1));
        end else begin
            mx_rd_addr = mx_head_reg;
            mn_rd_addr = mn_head_reg;
        end
    end

    // memory write and registered read
    always_ff @(posedge aclk) begin
        if (state_reg == S_PUSH && mx_tail_reg < DEPTH_C) begin
            mx_val[ring(mx_head_reg, mx_tail_reg)] <= v_reg;
            mx_pos[ring(mx_head_reg, mx_tail_reg)] <= pos_reg;
        end
        if (state_reg == S_PUSH && mn_tail_reg < DEPTH_C) begin
            mn_val[ring(mn_head_reg, mn_tail_reg)] <= v_reg;
            mn_pos[ring(mn_head_reg, mn_tail_reg)] <= pos_reg;
        end
        rd_mxv_reg <= mx_val[mx_rd_addr];
        rd_mxp_reg <= mx_pos[mx_rd_addr];
        rd_mnv_reg <= mn_val[mn_rd_addr];
        rd_mnp_reg <= mn_pos[mn_rd_addr];
    end

    assign q_ready = (state_reg == S_IDLE);
    assign busy    = (state_reg != S_IDLE) || out_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // window spread against the limit, both widened to a common width
    logic [VALUE_BITS-1:0] spread;
    logic over;
    assign spread = rd_mxv_reg - rd_mnv_reg;
    assign over   = DW'(spread) > DW'(range_limit);

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            mx_head_reg   <= '0;
            mn_head_reg   <= '0;
            mx_tail_reg   <= '0;
            mn_tail_reg   <= '0;
            pos_reg       <= '0;
            start_reg     <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
            side_reg      <= 1'b0;
        end else begin
            if (out_valid_reg && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        v_reg    <= q_value;
                        last_reg <= q_last;
                        pos_reg  <= pos_reg + PW'(1);
                        // window cap: start moves before the push
                        if ((pos_reg + PW'(1) - start_reg) > DEPTH_P) begin
                            start_reg   <= start_reg + PW'(1);
                            side_reg    <= 1'b1;   // marks cap head drop
                            state_reg   <= S_HEADR;
                        end else begin
                            side_reg  <= 1'b0;
                            state_reg <= S_TAILR;
                        end
                    end
                end
                S_TAILR: begin
                    state_reg <= S_TAILC;
                end
                S_TAILC: begin
                    // pop dominated tail entries, both deques in parallel
                    if (mx_tail_reg != '0 && rd_mxv_reg <= v_reg) begin
                        mx_tail_reg <= mx_tail_reg - CW'(1);
                    end
                    if (mn_tail_reg != '0 && rd_mnv_reg >= v_reg) begin
                        mn_tail_reg <= mn_tail_reg - CW'(1);
                    end
                    if ((mx_tail_reg != '0 && rd_mxv_reg <= v_reg) ||
                        (mn_tail_reg != '0 && rd_mnv_reg >= v_reg))
                        state_reg <= S_TAILR;
                    else
                        state_reg <= S_PUSH;
                end
                S_PUSH: begin
                    if (mx_tail_reg < DEPTH_C) mx_tail_reg <= mx_tail_reg + CW'(1);
                    if (mn_tail_reg < DEPTH_C) mn_tail_reg <= mn_tail_reg + CW'(1);
                    state_reg <= S_HEADR;
                end
                S_HEADR: begin
                    state_reg <= S_HEADC;
                end
                S_HEADC: begin
                    // drop expired heads one per deque per pass
                    if ((mx_tail_reg != '0 && mx_exp) ||
                        (mn_tail_reg != '0 && mn_exp)) begin
                        if (mx_tail_reg != '0 && mx_exp) begin
                            mx_head_reg <= ring(mx_head_reg, CW'(1));
                            mx_tail_reg <= mx_tail_reg - CW'(1);
                        end
                        if (mn_tail_reg != '0 && mn_exp) begin
                            mn_head_reg <= ring(mn_head_reg, CW'(1));
                            mn_tail_reg <= mn_tail_reg - CW'(1);
                        end
                        state_reg <= S_HEADR;
                    end else if (side_reg) begin
                        side_reg  <= 1'b0;
                        state_reg <= S_TAILR;
                    end else begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    // shrink window while range exceeded
                    if (mx_tail_reg != '0 && mn_tail_reg != '0 && over &&
                        win_len > PW'(1)) begin
                        start_reg <= start_reg + PW'(1);
                        state_reg <= S_HEADR;
                    end else if (!out_valid_reg || m_ready) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_reg.window_length <= win_len[lwwr_pkg::LEN_BITS-1:0];
                    out_reg.sequence_done <= last_reg;
                    if (win_len > {{(PW-lwwr_pkg::LEN_BITS){1'b0}}, best_reg}) begin
                        best_reg <= win_len[lwwr_pkg::LEN_BITS-1:0];
                        out_reg.best_length <= win_len[lwwr_pkg::LEN_BITS-1:0];
                    end else begin
                        out_reg.best_length <= best_reg;
                    end
                    if (last_reg) begin
                        mx_head_reg <= '0;
                        mn_head_reg <= '0;
                        mx_tail_reg <= '0;
                        mn_tail_reg <= '0;
                        pos_reg     <= '0;
                        start_reg   <= '0;
                        best_reg    <= '0;
                    end
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/longest_window_within_range_core.sv =====
// Each word passes idle, tail read, tail compare, push, head read, head compare,
// check and output; tail pops, head drops and window shrinks repeat read and compare.
// Each deque read is registered ahead of its compare, and the engine takes a word
// only when idle, so it cannot take a new word before it is through with the last.
// The input queue holds two words so upstream can run ahead of the engine.
// Reset: aresetn synchronous, active low; clears control state and range_limit.
// ----------------------------------------------------------------------------
// longest_window_within_range_core: longest window within range
// Streams values and reports the longest window whose max minus min stays
// within range_limit, with the best length so far.
// ----------------------------------------------------------------------------
module longest_window_within_range_core #(
    parameter int unsigned DEQUE_DEPTH = 1024,
    parameter int unsigned VALUE_BITS  = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [31:0]              cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  lwwr_pkg::in_word_t       s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output lwwr_pkg::out_word_t      m_data
);

    logic [31:0]           range_limit_reg;
    logic                  q_valid, q_ready, q_last, busy;
    logic [VALUE_BITS-1:0] q_value;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) range_limit_reg <= '0;
        else if (cfg_we) range_limit_reg <= cfg_wdata;
    end

    lwwr_front #(.VALUE_BITS(VALUE_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_value(q_value), .q_last(q_last)
    );

    lwwr_back #(.DEQUE_DEPTH(DEQUE_DEPTH), .VALUE_BITS(VALUE_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .range_limit(range_limit_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_value(q_value), .q_last(q_last),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data), .busy(busy)
    );

`ifndef SYNTH
    // a result never reports a window longer than the best so far
    a_len_le_best: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.window_length <= m_data.best_length))
        else $error("window longer than best");

    // a produced result has a nonzero window
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.window_length != '0))
        else $error("empty window reported");

    // the engine stays busy while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> busy)
        else $error("result pending while idle");
`endif

endmodule
